[rtl/core/rational_arithmetic_unit_macros.svh]
// assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// property that must hold whenever reset is released
`define RAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int CMD_BITS  = 3;
    localparam int RES_BITS  = 64;

    localparam logic [CMD_BITS-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_RED = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_EQ  = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_NE  = 3'd6;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        logic signed [31:0]  a_num;
        logic signed [31:0]  a_den;
        logic signed [31:0]  b_num;
        logic signed [31:0]  b_den;
    } in_word_t;

    typedef struct packed {
        logic signed [RES_BITS-1:0] res_num;
        logic signed [RES_BITS-1:0] res_den;
        logic                       compare_true;
        logic                       zero_divisor;
    } out_word_t;

    // datapath operation codes issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_FINISH,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_GCD_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_quot; // division step writes a quotient (num/den by gcd)
    } dp_cmd_t;

    typedef struct packed {
        logic is_reduce;
        logic y_zero;
        logic g_zero;
        logic div_last;
    } dp_stat_t;

    localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

endpackage

`default_nettype wire

[rtl/core/rau_stream_if.sv]
// ----------------------------------------------------------------------------
// rau_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add/sub/mul/div, euclid reduce and exact compare
// ----------------------------------------------------------------------------
// One word at a time. Compares go straight to the result; multiply and divide
// run the MUL1 and MUL2 passes, add and subtract also FIN. Reduce runs euclid
// steps (each one 33-step restoring remainder in the shared divider), then the
// two final quotients. The result is held until taken.
`default_nettype none

module rational_arithmetic_unit (
    input wire logic clk,
    input wire logic rst_n,
    rau_stream_if.sink   in_ch,
    rau_stream_if.source out_ch
);
    import rau_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .in_cmd    (in_ch.data.command),
        .stat      (stat),
        .cmd       (cmd)
    );

    rau_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_ch.data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_ch.data)
    );

endmodule

`default_nettype wire

[rtl/core/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shared 32x32 multiplier, restoring divider for euclid and quotients
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rau_pkg::in_word_t  in_word,
    input  wire rau_pkg::dp_cmd_t   cmd,
    output rau_pkg::dp_stat_t       stat,
    output rau_pkg::out_word_t      result
);
    import rau_pkg::*;

    localparam int W = WORD_BITS;

    logic [CMD_BITS-1:0]      cmd_reg;
    logic signed [W-1:0]      an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RES_BITS-1:0] p1_reg, p1_next;
    logic signed [RES_BITS-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic                     cmp_reg, cmp_next, zd_reg, zd_next;
    // euclid state: x, y as signed values
    logic signed [W:0]        x_reg, x_next, y_reg, y_next;
    // divider: remainder, quotient, divisor magnitude, counter
    logic [W:0]               rem_reg, rem_next;
    logic [W:0]               quo_reg, quo_next;
    logic [W:0]               dvs_reg, dvs_next;
    logic                     neg_reg, neg_next, dneg_reg, dneg_next;
    logic [DIV_CNT_BITS:0]    cnt_reg, cnt_next;

    function automatic logic signed [W-1:0] sx(input logic [31:0] v);
        return W'(v);
    endfunction

    logic signed [W-1:0] ma, mb;
    logic signed [2*W-1:0] prod;
    logic [W:0] dvd_abs, dvs_abs, trial_rem;
    logic [W+1:0] trial;
    logic signed [W:0] gval;

    // multiplier operand select
    always_comb
    begin
        ma = ad_reg;
        mb = bd_reg;
        if (cmd.op == OP_MUL1)
        begin
            ma = an_reg;
            mb = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
        end
        else if (cmd.op == OP_MUL2)
        begin
            ma = ad_reg;
            mb = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB || cmd_reg == CMD_DIV)
                ? bn_reg : bd_reg;
        end
    end

    assign prod = ma * mb;
    assign gval = x_reg;

    // restoring division: remainder shifts in dividend bit from quotient register
    assign trial = {rem_reg, quo_reg[W]} - {1'b0, dvs_reg};
    assign trial_rem = trial[W:0];

    always_comb
    begin
        p1_next   = p1_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        cmp_next  = cmp_reg;
        zd_next   = zd_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        dneg_next = dneg_reg;
        cnt_next  = cnt_reg;
        dvd_abs   = '0;
        dvs_abs   = '0;
        case (cmd.op)
            OP_LOAD:
            begin
                rn_next  = '0;
                rd_next  = '0;
                zd_next  = 1'b0;
                cmp_next = 1'b0;
                x_next   = (W+1)'(sx(in_word.a_num));
                y_next   = (W+1)'(sx(in_word.a_den));
                if (in_word.command == CMD_EQ)
                    cmp_next = sx(in_word.a_num) == sx(in_word.b_num)
                            && sx(in_word.a_den) == sx(in_word.b_den);
                else if (in_word.command == CMD_NE)
                    cmp_next = sx(in_word.a_num) != sx(in_word.b_num)
                            || sx(in_word.a_den) != sx(in_word.b_den);
            end
            OP_MUL1:
                p1_next = RES_BITS'(prod);
            OP_MUL2:
            begin
                if (cmd_reg == CMD_ADD)
                    rn_next = p1_reg + RES_BITS'(prod);
                else if (cmd_reg == CMD_SUB)
                    rn_next = p1_reg - RES_BITS'(prod);
                else if (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV)
                begin
                    rn_next = p1_reg;
                    rd_next = RES_BITS'(prod);
                end
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                    p1_next = '0;
            end
            OP_FINISH:
            begin
                // add/sub: denominator product needs a third pass
                rd_next = RES_BITS'(prod);
            end
            OP_DIV_START:
            begin
                // euclid: x % y ; quotient: a / g
                if (cmd.div_quot)
                begin
                    if (!rn_reg[0])
                        dvd_abs = (W+1)'(sx(an_reg));
                    else
                        dvd_abs = (W+1)'(sx(ad_reg));
                    neg_next  = dvd_abs[W];
                    dneg_next = dvd_abs[W] ^ gval[W];
                    dvd_abs   = dvd_abs[W] ? -dvd_abs : dvd_abs;
                    dvs_abs   = gval[W] ? -gval : gval;
                end
                else
                begin
                    neg_next  = x_reg[W];
                    dneg_next = x_reg[W];
                    dvd_abs   = x_reg[W] ? -x_reg : x_reg;
                    dvs_abs   = y_reg[W] ? -y_reg : y_reg;
                end
                rem_next = '0;
                quo_next = dvd_abs;
                dvs_next = dvs_abs;
                cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                if (!trial[W+1])
                    rem_next = trial_rem;
                else
                    rem_next = {rem_reg[W-1:0], quo_reg[W]};
                quo_next = {quo_reg[W-1:0], ~trial[W+1]};
                cnt_next = cnt_reg + 1'b1;
                if (cmd.div_quot && cnt_reg == (DIV_CNT_BITS+1)'(W))
                begin
                    // last step: write signed quotient
                    if (!rn_reg[0])
                        p1_next = RES_BITS'(dneg_reg
                            ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next}));
                    else
                    begin
                        rd_next = RES_BITS'(dneg_reg
                            ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next}));
                        rn_next = p1_reg;
                    end
                end
                if (!cmd.div_quot && cnt_reg == (DIV_CNT_BITS+1)'(W))
                begin
                    // euclid step done: remainder takes the sign of x
                    x_next = y_reg;
                    y_next = neg_reg ? -$signed(rem_next) : $signed(rem_next);
                end
            end
            OP_GCD_NEXT:
            begin
                if (cmd.div_quot)
                begin
                    // toggle to denominator pass; rn_reg bit 0 marks it
                    rn_next = 64'd1;
                end
                else if (y_reg == '0)
                begin
                    // gcd found in x; zero gcd passes operands through
                    rn_next = '0;
                    if (x_reg == '0)
                    begin
                        zd_next = 1'b1;
                        rn_next = RES_BITS'(an_reg);
                        rd_next = RES_BITS'(ad_reg);
                    end
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            cmd_reg <= in_word.command;
            an_reg  <= sx(in_word.a_num);
            ad_reg  <= sx(in_word.a_den);
            bn_reg  <= sx(in_word.b_num);
            bd_reg  <= sx(in_word.b_den);
        end
        p1_reg   <= p1_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        cmp_reg  <= cmp_next;
        zd_reg   <= zd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        dneg_reg <= dneg_next;
        cnt_reg  <= cnt_next;
    end

    assign stat.is_reduce = cmd_reg == CMD_RED;
    assign stat.y_zero    = y_reg == '0;
    assign stat.g_zero    = x_reg == '0;
    assign stat.div_last  = cnt_reg == (DIV_CNT_BITS+1)'(W);

    always_comb
    begin
        result.res_num      = rn_reg;
        result.res_den      = rd_reg;
        result.compare_true = cmp_reg;
        result.zero_divisor = zd_reg;
        if (!(cmd_reg == CMD_ADD || cmd_reg == CMD_SUB || cmd_reg == CMD_MUL
              || cmd_reg == CMD_DIV || cmd_reg == CMD_RED))
        begin
            result.res_num = '0;
            result.res_den = '0;
        end
    end

    logic unused_ok;
    assign unused_ok = rst_n;

endmodule

`default_nettype wire

[rtl/core/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for the arithmetic passes and the euclid / quotient divisions
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic [rau_pkg::CMD_BITS-1:0] in_cmd,
    input  wire rau_pkg::dp_stat_t stat,
    output rau_pkg::dp_cmd_t       cmd
);
    import rau_pkg::*;

    `include "rational_arithmetic_unit_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_FIN   = 4'd3;
    localparam logic [3:0] S_GTEST = 4'd4;
    localparam logic [3:0] S_GDIV  = 4'd5;
    localparam logic [3:0] S_GSTEP = 4'd6;
    localparam logic [3:0] S_QDIV  = 4'd7;
    localparam logic [3:0] S_QSTEP = 4'd8;
    localparam logic [3:0] S_QNEXT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic       arith_reg, arith_next;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        arith_next = arith_reg;
        cmd.op       = OP_NONE;
        cmd.div_quot = 1'b0;
        in_ready   = state_reg == S_IDLE;
        out_valid  = state_reg == S_DONE;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    arith_next = in_cmd == CMD_ADD || in_cmd == CMD_SUB;
                    if (in_cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV})
                        state_next = S_MUL1;
                    else if (in_cmd == CMD_RED)
                        state_next = S_GTEST;
                    else
                        state_next = S_DONE;
                end
            S_MUL1:
            begin
                cmd.op = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op = OP_MUL2;
                state_next = arith_reg ? S_FIN : S_DONE;
            end
            S_FIN:
            begin
                cmd.op = OP_FINISH;
                state_next = S_DONE;
            end
            S_GTEST:
            begin
                cmd.op = OP_GCD_NEXT;
                if (stat.y_zero)
                begin
                    pass_next  = 1'b0;
                    state_next = stat.g_zero ? S_DONE : S_QDIV;
                end
                else
                    state_next = S_GDIV;
            end
            S_GDIV:
            begin
                cmd.op = OP_DIV_START;
                state_next = S_GSTEP;
            end
            S_GSTEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                    state_next = S_GTEST;
            end
            S_QDIV:
            begin
                cmd.op = OP_DIV_START;
                cmd.div_quot = 1'b1;
                state_next = S_QSTEP;
            end
            S_QSTEP:
            begin
                cmd.op = OP_DIV_STEP;
                cmd.div_quot = 1'b1;
                if (stat.div_last)
                    state_next = pass_reg ? S_DONE : S_QNEXT;
            end
            S_QNEXT:
            begin
                cmd.op = OP_GCD_NEXT;
                cmd.div_quot = 1'b1;
                pass_next = 1'b1;
                state_next = S_QDIV;
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            arith_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            arith_reg <= arith_next;
        end
    end

    `RAU_ASSERT(a_excl, !(in_ready && out_valid), "ready and valid at once")
    `RAU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
    `RAU_ASSERT_NEXT(a_take, in_valid && in_ready, !in_ready, "second word taken")

endmodule

`default_nettype wire
